/* rtl/sia_pkg.sv */
`timescale 1ns / 1ps
package sia_pkg;

	// Full operand and result width carried on the stream ports
	localparam int unsigned FULL_BITS     = 128;
	localparam int unsigned HALF_BITS     = 64;
	localparam int unsigned WORD_BITS_DEF = 128;

	// Slave-side tdata layout, lowest bit first
	localparam int unsigned CMD_BITS   = 5;
	localparam int unsigned SHIFT_BITS = 8;
	localparam int unsigned CMD_LSB    = 0;
	localparam int unsigned A_HI_LSB   = CMD_LSB + CMD_BITS;
	localparam int unsigned A_LO_LSB   = A_HI_LSB + HALF_BITS;
	localparam int unsigned B_HI_LSB   = A_LO_LSB + HALF_BITS;
	localparam int unsigned B_LO_LSB   = B_HI_LSB + HALF_BITS;
	localparam int unsigned SHIFT_LSB  = B_LO_LSB + HALF_BITS;
	localparam int unsigned S_TDATA_W  = 272;

	// Master-side tdata layout, lowest bit first
	localparam int unsigned R_HI_LSB  = 0;
	localparam int unsigned R_LO_LSB  = R_HI_LSB + HALF_BITS;
	localparam int unsigned CMP_BIT   = R_LO_LSB + HALF_BITS;
	localparam int unsigned OVF_BIT   = CMP_BIT + 1;
	localparam int unsigned DZ_BIT    = OVF_BIT + 1;
	localparam int unsigned M_TDATA_W = 136;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_ADD = 5'd0,
		CMD_SUB = 5'd1,
		CMD_MUL = 5'd2,
		CMD_DIV = 5'd3,
		CMD_AND = 5'd4,
		CMD_OR  = 5'd5,
		CMD_XOR = 5'd6,
		CMD_NOT = 5'd7,
		CMD_SHL = 5'd8,
		CMD_SAR = 5'd9,
		CMD_ROL = 5'd10,
		CMD_ROR = 5'd11,
		CMD_EQ  = 5'd12,
		CMD_GT  = 5'd13,
		CMD_LT  = 5'd14,
		CMD_GE  = 5'd15,
		CMD_LE  = 5'd16
	} cmd_t;

endpackage

/* rtl/signed_int128_alu.sv */
`timescale 1ns / 1ps
// Channel   Dir  Fields (tdata, lowest bit first)
// s_*       in   cmd[4:0] a_hi[68:5] a_lo[132:69] b_hi[196:133] b_lo[260:197]
//                shift_amount[268:261], zero pad to 272
// m_*       out  r_hi[63:0] r_lo[127:64] compare_true[128] mul_overflow[129]
//                div_by_zero[130], zero pad to 136
//
// Sequencing: add/sub/logic/shift/rotate/compare pass through ST_OP and ST_DONE;
// mul and div pass through ST_MAG_A, ST_MAG_B, ST_LOOP, ST_FIX and ST_DONE, one radix-2 step
// a cycle in ST_LOOP through the single shared (WORD_BITS+1)-bit adder/subtractor.
// s_tready is high only while the sequencer idles; one transaction is in work at a time.
// The result sits in its own output register, so a new transaction is taken while it waits.
// A stalled m_tready holds the finished result; the sequencer waits in its final state.
// Reset (arst_n low) clears the sequencer and m_tvalid at once; payload holds no reset.
module signed_int128_alu #(
	parameter int unsigned WORD_BITS = sia_pkg::WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [sia_pkg::S_TDATA_W-1:0] s_tdata,  // cmd, a_hi, a_lo, b_hi, b_lo, shift_amount
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [sia_pkg::M_TDATA_W-1:0] m_tdata   // r_hi, r_lo, compare_true, mul_overflow,
	                                                // div_by_zero
);
	import sia_pkg::*;

	localparam int unsigned W     = WORD_BITS;
	localparam int unsigned CNT_W = $clog2(W);
	localparam logic [W-1:0] W_MSB = {1'b1, {(W-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OP,
		ST_MAG_A,
		ST_MAG_B,
		ST_LOOP,
		ST_FIX,
		ST_DONE
	} state_t;

	state_t              state_q;
	cmd_t                cmd_q;
	logic [W-1:0]        opa_q;
	logic [W-1:0]        opb_q;
	logic [SHIFT_BITS-1:0] sh_q;
	logic                neg_q;
	logic [W-1:0]        hi_q;
	logic [W-1:0]        lo_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [W-1:0]        res_q;
	logic                cmp_q;
	logic                ovf_q;
	logic                dz_q;
	logic                mvalid_q;
	logic [W-1:0]        out_r_q;
	logic                out_cmp_q;
	logic                out_ovf_q;
	logic                out_dz_q;

	logic [FULL_BITS-1:0] a_in;
	logic [FULL_BITS-1:0] b_in;
	cmd_t                 cmd_in;
	logic                 s_acc;

	logic [W:0]   ax;
	logic [W:0]   ay;
	logic         asub;
	logic [W:0]   asum;
	logic         acarry;

	logic         is_div;
	logic         lt;
	logic         eq;
	logic [W-1:0] op_res;
	logic         op_cmp;
	logic [W-1:0] mb;
	logic         mul_ovf;
	logic [FULL_BITS-1:0] rext;

	// Unpack the operands; only the low W bits of each take part
	assign a_in   = {s_tdata[A_HI_LSB +: HALF_BITS], s_tdata[A_LO_LSB +: HALF_BITS]};
	assign b_in   = {s_tdata[B_HI_LSB +: HALF_BITS], s_tdata[B_LO_LSB +: HALF_BITS]};
	assign cmd_in = cmd_t'(s_tdata[CMD_LSB +: CMD_BITS]);

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign is_div   = (cmd_q == CMD_DIV);

	// Operand steering for the shared adder, one use per state
	always_comb begin
		ax   = '0;
		ay   = '0;
		asub = 1'b0;
		case (state_q)
			ST_OP: begin
				ax   = {opa_q[W-1], opa_q};
				ay   = {opb_q[W-1], opb_q};
				asub = (cmd_q != CMD_ADD);
			end
			ST_MAG_A: begin
				ay   = {1'b0, opa_q};
				asub = 1'b1;
			end
			ST_MAG_B: begin
				ay   = {1'b0, opb_q};
				asub = 1'b1;
			end
			ST_LOOP: begin
				if (is_div) begin
					// trial subtract of the divisor from the shifted partial remainder
					ax   = {hi_q, lo_q[W-1]};
					ay   = {1'b0, opb_q};
					asub = 1'b1;
				end else begin
					// add the multiplicand into the upper half when the low bit is set
					ax   = {1'b0, hi_q};
					ay   = lo_q[0] ? {1'b0, opa_q} : '0;
				end
			end
			ST_FIX: begin
				ay   = {1'b0, lo_q};
				asub = 1'b1;
			end
			default: begin
				ax   = '0;
			end
		endcase
	end

	sia_addsub #(
		.WIDTH (W + 1)
	) u_addsub (
		.x     (ax),
		.y     (ay),
		.sub   (asub),
		.sum   (asum),
		.carry (acarry)
	);

	// Single-step operations; the sign of the widened difference gives signed less-than
	assign lt = asum[W];
	assign eq = (opa_q == opb_q);

	always_comb begin
		op_res = '0;
		op_cmp = 1'b0;
		case (cmd_q)
			CMD_ADD, CMD_SUB: op_res = asum[W-1:0];
			CMD_AND:          op_res = opa_q & opb_q;
			CMD_OR:           op_res = opa_q | opb_q;
			CMD_XOR:          op_res = opa_q ^ opb_q;
			CMD_NOT:          op_res = ~opa_q;
			CMD_SHL:          op_res = opa_q << sh_q;
			CMD_SAR:          op_res = $signed(opa_q) >>> sh_q;
			CMD_ROL:          op_res = {opa_q[W-2:0], opa_q[W-1]};
			CMD_ROR:          op_res = {opa_q[0], opa_q[W-1:1]};
			CMD_EQ:           op_cmp = eq;
			CMD_GT:           op_cmp = !lt && !eq;
			CMD_LT:           op_cmp = lt;
			CMD_GE:           op_cmp = !lt;
			CMD_LE:           op_cmp = lt || eq;
			default:          op_res = '0;
		endcase
	end

	// Divisor magnitude as it leaves the second negate step
	assign mb = opb_q[W-1] ? asum[W-1:0] : opb_q;

	// Product needs more than W-1 magnitude bits, except the most negative value
	assign mul_ovf = ((hi_q != '0) || lo_q[W-1]) &&
	                 !(neg_q && (hi_q == '0) && (lo_q == W_MSB));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mvalid_q <= 1'b0;
		end else begin
			// drop the delivered result unless the final state refills the register
			if (mvalid_q && m_tready && (state_q != ST_DONE)) begin
				mvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						cmd_q <= cmd_in;
						opa_q <= a_in[W-1:0];
						opb_q <= b_in[W-1:0];
						sh_q  <= s_tdata[SHIFT_LSB +: SHIFT_BITS];
						neg_q <= a_in[W-1] ^ b_in[W-1];
						if (cmd_in inside {CMD_MUL, CMD_DIV}) begin
							state_q <= ST_MAG_A;
						end else begin
							state_q <= ST_OP;
						end
					end
				end
				ST_OP: begin
					res_q   <= op_res;
					cmp_q   <= op_cmp;
					ovf_q   <= 1'b0;
					dz_q    <= 1'b0;
					state_q <= ST_DONE;
				end
				ST_MAG_A: begin
					if (opa_q[W-1]) begin
						opa_q <= asum[W-1:0];
					end
					state_q <= ST_MAG_B;
				end
				ST_MAG_B: begin
					opb_q   <= mb;
					hi_q    <= '0;
					lo_q    <= is_div ? opa_q : mb;
					cnt_q   <= CNT_W'(W - 1);
					state_q <= ST_LOOP;
				end
				ST_LOOP: begin
					if (is_div) begin
						hi_q <= acarry ? asum[W-1:0] : ax[W-1:0];
						lo_q <= {lo_q[W-2:0], acarry};
					end else begin
						hi_q <= asum[W:1];
						lo_q <= {asum[0], lo_q[W-1:1]};
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					res_q   <= neg_q ? asum[W-1:0] : lo_q;
					cmp_q   <= 1'b0;
					ovf_q   <= !is_div && mul_ovf;
					dz_q    <= is_div && (opb_q == '0);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!mvalid_q || m_tready) begin
						out_r_q   <= res_q;
						out_cmp_q <= cmp_q;
						out_ovf_q <= ovf_q;
						out_dz_q  <= dz_q;
						mvalid_q  <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Sign-extend the W-bit result to the full port width
	assign rext     = FULL_BITS'($signed(out_r_q));
	assign m_tvalid = mvalid_q;
	assign m_tdata  = {5'd0, out_dz_q, out_ovf_q, out_cmp_q, rext[HALF_BITS-1:0],
	                   rext[FULL_BITS-1:HALF_BITS]};

	a_short_path : assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && (cmd_in != CMD_MUL) && (cmd_in != CMD_DIV) |=> state_q == ST_OP)
		else $error("single-step command did not go to the operate state");

	a_loop_exit : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOP) && (cnt_q == '0) |=> state_q == ST_FIX)
		else $error("iteration count ran past the last step");

	a_flags_excl : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $countones({m_tdata[CMP_BIT], m_tdata[OVF_BIT], m_tdata[DZ_BIT]}) <= 1)
		else $error("more than one status flag set");

	a_cmp_zero : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[CMP_BIT] |-> m_tdata[FULL_BITS-1:0] == '0)
		else $error("compare result carries a nonzero word");

	a_deliver : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && (!m_tvalid || m_tready) |=> m_tvalid && (state_q == ST_IDLE))
		else $error("finished result was not moved to the output register");

endmodule

/* rtl/sia_addsub.sv */
`timescale 1ns / 1ps
module sia_addsub #(
	parameter int unsigned WIDTH = sia_pkg::WORD_BITS_DEF + 1
) (
	input  logic [WIDTH-1:0] x,
	input  logic [WIDTH-1:0] y,
	input  logic             sub,
	output logic [WIDTH-1:0] sum,
	output logic             carry
);

	logic [WIDTH:0] full;

	// sub: x + ~y + 1; carry set means no borrow (x >= y unsigned)
	assign full  = {1'b0, x} + {1'b0, (sub ? ~y : y)} + {{WIDTH{1'b0}}, sub};
	assign sum   = full[WIDTH-1:0];
	assign carry = full[WIDTH];

endmodule

/* tb/signed_int128_alu_tb.sv */
`timescale 1ns / 1ps
module signed_int128_alu_tb;
	import sia_pkg::*;

	localparam int RESET_CYCLES   = 5;
	localparam int SLOW_LATENCY   = WORD_BITS_DEF + 5;
	localparam int DRAIN_CYCLES   = 2 * SLOW_LATENCY;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS    = 306;

	localparam logic [FULL_BITS-1:0] ALL_ONES = '1;
	localparam logic [FULL_BITS-1:0] MIN_NEG  = {1'b1, {(FULL_BITS-1){1'b0}}};
	localparam logic [FULL_BITS-1:0] MAX_POS  = {1'b0, {(FULL_BITS-1){1'b1}}};

	// opcode values past the last defined operation
	localparam logic [CMD_BITS-1:0] CMD_FIRST_UNUSED = CMD_LE + 1;
	localparam logic [CMD_BITS-1:0] CMD_LAST_UNUSED  = (1 << CMD_BITS) - 1;
	localparam int                  SHIFT_MAX        = (1 << SHIFT_BITS) - 1;

	typedef struct packed {
		logic [CMD_BITS-1:0]   cmd;
		logic [HALF_BITS-1:0]  a_hi;
		logic [HALF_BITS-1:0]  a_lo;
		logic [HALF_BITS-1:0]  b_hi;
		logic [HALF_BITS-1:0]  b_lo;
		logic [SHIFT_BITS-1:0] shift_amount;
	} alu_op_t;

	typedef struct packed {
		logic [HALF_BITS-1:0] r_hi;
		logic [HALF_BITS-1:0] r_lo;
		logic                 compare_true;
		logic                 mul_overflow;
		logic                 div_by_zero;
	} alu_res_t;

	// one row of the directed table; fixed rows carry a hand-written result
	typedef struct packed {
		alu_op_t  op;
		logic     fixed;
		alu_res_t res;
	} dir_row_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;  // cmd, a_hi, a_lo, b_hi, b_lo, shift_amount
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // r_hi, r_lo, compare_true, mul_overflow,
	                                      // div_by_zero

	alu_res_t pending_results[$];
	int       mismatch_count = 0;
	int       quiet_cycles   = 0;
	int       src_idle_pct   = 0;
	int       sink_stall_pct = 0;

	signed_int128_alu dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Work out the result of one transaction at the full 128-bit word width.
	function automatic alu_res_t compute_alu_result(alu_op_t op);
		logic signed [FULL_BITS-1:0] a;
		logic signed [FULL_BITS-1:0] b;
		logic [FULL_BITS-1:0]        ma;
		logic [FULL_BITS-1:0]        mb;
		logic [FULL_BITS-1:0]        q;
		logic [FULL_BITS-1:0]        r;
		logic [2*FULL_BITS-1:0]      prod;
		logic                        neg_a;
		logic                        neg_b;
		logic                        sign_differs;
		alu_res_t                    res;
		a            = {op.a_hi, op.a_lo};
		b            = {op.b_hi, op.b_lo};
		neg_a        = a[FULL_BITS-1];
		neg_b        = b[FULL_BITS-1];
		ma           = neg_a ? -a : a;
		mb           = neg_b ? -b : b;
		sign_differs = neg_a != neg_b;
		res          = '0;
		r            = '0;
		case (op.cmd)
			CMD_ADD: r = a + b;
			CMD_SUB: r = a - b;
			CMD_MUL: begin
				prod = {{FULL_BITS{1'b0}}, ma} * {{FULL_BITS{1'b0}}, mb};
				q    = prod[FULL_BITS-1:0];
				// the magnitude fits only below bit 127, except the most negative product
				res.mul_overflow = (prod[2*FULL_BITS-1:FULL_BITS] != '0) ||
					(q[FULL_BITS-1] && !(sign_differs && q == MIN_NEG));
				r = sign_differs ? -q : q;
			end
			CMD_DIV: begin
				// a zero divisor leaves every quotient bit set
				res.div_by_zero = (mb == '0);
				q = (mb == '0) ? ALL_ONES : ma / mb;
				r = sign_differs ? -q : q;
			end
			CMD_AND: r = a & b;
			CMD_OR:  r = a | b;
			CMD_XOR: r = a ^ b;
			CMD_NOT: r = ~a;
			CMD_SHL: r = (op.shift_amount >= FULL_BITS) ? '0 : a << op.shift_amount;
			CMD_SAR: begin
				// keep the shift in a signed expression so the sign bit fills in
				if (op.shift_amount >= FULL_BITS)
					r = {FULL_BITS{neg_a}};
				else
					r = a >>> op.shift_amount;
			end
			CMD_ROL: r = {a[FULL_BITS-2:0], a[FULL_BITS-1]};
			CMD_ROR: r = {a[0], a[FULL_BITS-1:1]};
			CMD_EQ:  res.compare_true = (a == b);
			CMD_GT:  res.compare_true = (a > b);
			CMD_LT:  res.compare_true = (a < b);
			CMD_GE:  res.compare_true = (a >= b);
			CMD_LE:  res.compare_true = (a <= b);
			default: r = '0;
		endcase
		res.r_hi = r[FULL_BITS-1:HALF_BITS];
		res.r_lo = r[HALF_BITS-1:0];
		return res;
	endfunction

	function automatic dir_row_t dir_row(logic [CMD_BITS-1:0] cmd, logic [FULL_BITS-1:0] a,
			logic [FULL_BITS-1:0] b, logic [SHIFT_BITS-1:0] k, logic fixed,
			logic [FULL_BITS-1:0] r, logic cmp, logic ovf, logic dz);
		dir_row_t row;
		row.op.cmd              = cmd;
		row.op.a_hi             = a[FULL_BITS-1:HALF_BITS];
		row.op.a_lo             = a[HALF_BITS-1:0];
		row.op.b_hi             = b[FULL_BITS-1:HALF_BITS];
		row.op.b_lo             = b[HALF_BITS-1:0];
		row.op.shift_amount     = k;
		row.fixed               = fixed;
		row.res.r_hi            = r[FULL_BITS-1:HALF_BITS];
		row.res.r_lo            = r[HALF_BITS-1:0];
		row.res.compare_true    = cmp;
		row.res.mul_overflow    = ovf;
		row.res.div_by_zero     = dz;
		return row;
	endfunction

	// Operand mix: full random, plus small, extreme and sign-filled values.
	function automatic logic [FULL_BITS-1:0] rand_operand();
		logic [15:0]                 small_val;
		logic signed [FULL_BITS-1:0] wide;
		small_val = $urandom;
		wide      = {$urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(9))
			0, 1, 2, 3: return wide;
			4, 5:       return {{(FULL_BITS-16){small_val[15]}}, small_val};
			6: begin
				case ($urandom_range(4))
					0:       return '0;
					1:       return 1;
					2:       return ALL_ONES;
					3:       return MAX_POS;
					default: return MIN_NEG;
				endcase
			end
			7:          return wide >>> $urandom_range(FULL_BITS - 1);
			default:    return {{HALF_BITS{small_val[0]}}, wide[HALF_BITS-1:0]};
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [HALF_BITS-1:0] got,
			input logic [HALF_BITS-1:0] want);
		$display("%0t ns  %s: got %h, want %h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Present one transaction, hold it until accepted, then queue its expected result.
	task automatic send_op(input alu_op_t op, input alu_res_t expected);
		logic [S_TDATA_W-1:0] word;
		word                            = '0;
		word[CMD_LSB +: CMD_BITS]       = op.cmd;
		word[A_HI_LSB +: HALF_BITS]     = op.a_hi;
		word[A_LO_LSB +: HALF_BITS]     = op.a_lo;
		word[B_HI_LSB +: HALF_BITS]     = op.b_hi;
		word[B_LO_LSB +: HALF_BITS]     = op.b_lo;
		word[SHIFT_LSB +: SHIFT_BITS]   = op.shift_amount;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(expected);
	endtask

	// Stall the result side at the rate of the current phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Count cycles in which no transaction moves on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Compare each returned result with the oldest pending expectation.
	always @(posedge clk) begin : result_check
		alu_res_t got;
		alu_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.r_hi         = m_tdata[R_HI_LSB +: HALF_BITS];
			got.r_lo         = m_tdata[R_LO_LSB +: HALF_BITS];
			got.compare_true = m_tdata[CMP_BIT];
			got.mul_overflow = m_tdata[OVF_BIT];
			got.div_by_zero  = m_tdata[DZ_BIT];
			if (pending_results.size() == 0) begin
				report_mismatch("result with no transaction pending, r_lo", got.r_lo, '0);
			end else begin
				want = pending_results.pop_front();
				if (got.r_hi !== want.r_hi)
					report_mismatch("r_hi", got.r_hi, want.r_hi);
				if (got.r_lo !== want.r_lo)
					report_mismatch("r_lo", got.r_lo, want.r_lo);
				if (got.compare_true !== want.compare_true)
					report_mismatch("compare_true", got.compare_true, want.compare_true);
				if (got.mul_overflow !== want.mul_overflow)
					report_mismatch("mul_overflow", got.mul_overflow, want.mul_overflow);
				if (got.div_by_zero !== want.div_by_zero)
					report_mismatch("div_by_zero", got.div_by_zero, want.div_by_zero);
			end
		end
	end

	initial begin : watchdog
		while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
		$display("signed_int128_alu: mismatch");
		$finish;
	end

	initial begin : stimulus
		dir_row_t             directed_rows[$];
		alu_op_t              op;
		logic [FULL_BITS-1:0] a;
		logic [FULL_BITS-1:0] b;
		int                   cmd_pick;
		int                   src_pct[4];
		int                   sink_pct[4];
		src_pct  = '{0, 80, 0, 27};
		sink_pct = '{0, 0, 80, 27};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: carry chains, wraps, flag cases, saturated shifts, every opcode.
		directed_rows.push_back(dir_row(CMD_ADD, MAX_POS, 1, 0, 1, MIN_NEG, 0, 0, 0));
		directed_rows.push_back(dir_row(CMD_ADD, {{HALF_BITS{1'b0}}, {HALF_BITS{1'b1}}}, 1,
			0, 1, {{(HALF_BITS-1){1'b0}}, 1'b1, {HALF_BITS{1'b0}}}, 0, 0, 0));
		directed_rows.push_back(dir_row(CMD_SUB, 0, 1, 0, 1, ALL_ONES, 0, 0, 0));
		directed_rows.push_back(dir_row(CMD_MUL, MIN_NEG, ALL_ONES, 0, 1, MIN_NEG, 0, 1, 0));
		directed_rows.push_back(dir_row(CMD_MUL, MIN_NEG, 1, 0, 1, MIN_NEG, 0, 0, 0));
		directed_rows.push_back(dir_row(CMD_MUL, MIN_NEG >> 27, MIN_NEG >> 27, 0, 1, 0,
			0, 1, 0));
		directed_rows.push_back(dir_row(CMD_MUL, -3, 5, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(dir_row(CMD_MUL, MAX_POS, MAX_POS, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(dir_row(CMD_DIV, 1234, 0, 0, 1, ALL_ONES, 0, 0, 1));
		directed_rows.push_back(dir_row(CMD_DIV, -5, 0, 0, 1, 1, 0, 0, 1));
		directed_rows.push_back(dir_row(CMD_DIV, MIN_NEG, ALL_ONES, 0, 1, MIN_NEG, 0, 0, 0));
		directed_rows.push_back(dir_row(CMD_DIV, -7, 2, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(dir_row(CMD_AND, {64'hF0F0_F0F0_F0F0_F0F0, 64'h1234_5678_9ABC_DEF0},
			ALL_ONES >> 1, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(dir_row(CMD_OR, MIN_NEG, 64'h5555_5555_5555_5555, 0, 0, 0,
			0, 0, 0));
		directed_rows.push_back(dir_row(CMD_XOR, ALL_ONES, {64'hAAAA_AAAA_AAAA_AAAA,
			64'h5555_5555_5555_5555}, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(dir_row(CMD_NOT, 0, ALL_ONES, 0, 1, ALL_ONES, 0, 0, 0));
		directed_rows.push_back(dir_row(CMD_SHL, ALL_ONES, 0, SHIFT_MAX, 1, 0, 0, 0, 0));
		directed_rows.push_back(dir_row(CMD_SHL, 1, 0, FULL_BITS - 1, 1, MIN_NEG, 0, 0, 0));
		directed_rows.push_back(dir_row(CMD_SAR, MIN_NEG, 0, 200, 1, ALL_ONES, 0, 0, 0));
		directed_rows.push_back(dir_row(CMD_SAR, MAX_POS, 0, FULL_BITS, 1, 0, 0, 0, 0));
		directed_rows.push_back(dir_row(CMD_ROL, MIN_NEG, 0, 0, 1, 1, 0, 0, 0));
		directed_rows.push_back(dir_row(CMD_ROR, 1, 0, 0, 1, MIN_NEG, 0, 0, 0));
		directed_rows.push_back(dir_row(CMD_EQ, ALL_ONES, ALL_ONES, 0, 1, 0, 1, 0, 0));
		directed_rows.push_back(dir_row(CMD_GT, ALL_ONES, 0, 0, 1, 0, 0, 0, 0));
		directed_rows.push_back(dir_row(CMD_LT, ALL_ONES, 0, 0, 1, 0, 1, 0, 0));
		directed_rows.push_back(dir_row(CMD_GE, MIN_NEG, MAX_POS, 0, 1, 0, 0, 0, 0));
		directed_rows.push_back(dir_row(CMD_LE, MAX_POS, MAX_POS, 0, 1, 0, 1, 0, 0));
		directed_rows.push_back(dir_row(CMD_FIRST_UNUSED, ALL_ONES, ALL_ONES, SHIFT_MAX, 1, 0,
			0, 0, 0));
		directed_rows.push_back(dir_row(CMD_LAST_UNUSED, MIN_NEG, 7, 3, 1, 0, 0, 0, 0));

		foreach (directed_rows[i])
			send_op(directed_rows[i].op, directed_rows[i].fixed ? directed_rows[i].res :
				compute_alu_result(directed_rows[i].op));

		// Random phases: free flow, then idle sender, stalled receiver, and both.
		for (int phase = 0; phase < 4; phase++) begin
			src_idle_pct   = src_pct[phase];
			sink_stall_pct = sink_pct[phase];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				cmd_pick = ($urandom_range(19) == 0) ?
					$urandom_range(CMD_LAST_UNUSED, CMD_FIRST_UNUSED) :
					$urandom_range(CMD_LE);
				a = rand_operand();
				b = rand_operand();
				// hit equal operands and zero divisors more often than chance would
				case ($urandom_range(7))
					0:       b = a;
					1:       b = '0;
					default: ;
				endcase
				op.cmd          = cmd_pick;
				op.a_hi         = a[FULL_BITS-1:HALF_BITS];
				op.a_lo         = a[HALF_BITS-1:0];
				op.b_hi         = b[FULL_BITS-1:HALF_BITS];
				op.b_lo         = b[HALF_BITS-1:0];
				op.shift_amount = ($urandom_range(3) == 0) ? $urandom_range(SHIFT_MAX) :
					$urandom_range(FULL_BITS + 2);
				send_op(op, compute_alu_result(op));
			end
		end
		s_tvalid <= 1'b0;

		// Drain: wait for every pending result, then give the block time to misbehave.
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("signed_int128_alu: match");
		else
			$display("signed_int128_alu: mismatch");
		$finish;
	end

endmodule
